FILE: rtl/tccr_pkg.sv
// Shared types, constants and color table functions for the terminal cell color resolver.
package tccr_pkg;

	localparam int RGB_W      = 24;
	localparam int KIND_W     = 2;
	localparam int INDEX_W    = 8;
	localparam int FLAGS_W    = 4;
	localparam int SLOT_W     = 4;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [KIND_W-1:0] KIND_DEFAULT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INDEX   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RGB     = 2'd2;

	localparam logic ACTION_RESOLVE = 1'b0;
	localparam logic ACTION_WRITE   = 1'b1;

	localparam int FLAG_BOLD      = 0;
	localparam int FLAG_DIM       = 1;
	localparam int FLAG_REVERSE   = 2;
	localparam int FLAG_INVISIBLE = 3;

	localparam logic [RGB_W-1:0] HALF_MASK      = 24'h7F7F7F;
	localparam logic [RGB_W-1:0] DEFAULT_FG_RST = 24'hFFFFFF;
	localparam logic [RGB_W-1:0] DEFAULT_BG_RST = 24'h000000;

	localparam logic [INDEX_W-1:0] ANSI_COUNT  = 8'd16;
	localparam logic [INDEX_W-1:0] BRIGHT_BASE = 8'd8;
	localparam logic [INDEX_W-1:0] GREY_FIRST  = 8'd232;
	localparam logic [INDEX_W-1:0] CUBE_ROW    = 8'd36;
	localparam logic [INDEX_W-1:0] CUBE_SIDE   = 8'd6;
	localparam logic [INDEX_W-1:0] GREY_BASE   = 8'd8;
	localparam logic [INDEX_W-1:0] GREY_STEP   = 8'd10;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] fg_addr;
		logic [SLOT_W-1:0] bg_addr;
		logic [SLOT_W-1:0] ul_addr;
	} pal_rd_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [RGB_W-1:0]  data;
	} pal_wr_t;

	function automatic logic [7:0] cube_level(input logic [2:0] step);
		logic [7:0] lv;
		case (step)
			3'd0: lv = 8'd0;
			3'd1: lv = 8'd95;
			3'd2: lv = 8'd135;
			3'd3: lv = 8'd175;
			3'd4: lv = 8'd215;
			default: lv = 8'd255;
		endcase
		return lv;
	endfunction

	// Color of an index at or above 16: the 6x6x6 cube, then the grey ramp.
	function automatic logic [RGB_W-1:0] index_rgb(input logic [INDEX_W-1:0] n);
		logic [INDEX_W-1:0] c;
		logic [INDEX_W-1:0] rem;
		logic [INDEX_W-1:0] lv;
		logic [2:0]         r;
		logic [2:0]         g;
		logic [2:0]         b;
		c   = n - ANSI_COUNT;
		r   = 3'd0;
		g   = 3'd0;
		for (int k = 1; k < 6; k++) begin
			if (c >= INDEX_W'(k * 36))
				r = 3'(k);
		end
		rem = c - INDEX_W'(r) * CUBE_ROW;
		for (int k = 1; k < 6; k++) begin
			if (rem >= INDEX_W'(k * 6))
				g = 3'(k);
		end
		b   = 3'(rem - INDEX_W'(g) * CUBE_SIDE);
		lv  = GREY_BASE + (n - GREY_FIRST) * GREY_STEP;
		if (n >= GREY_FIRST)
			return {lv, lv, lv};
		return {cube_level(r), cube_level(g), cube_level(b)};
	endfunction

endpackage

FILE: rtl/tccr_ifs.sv
// Valid/ready channel interfaces for cell items and resolved results.
interface tccr_cell_if
	import tccr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               action;
	logic [KIND_W-1:0]  fg_kind;
	logic [RGB_W-1:0]   fg_value;
	logic [KIND_W-1:0]  bg_kind;
	logic [RGB_W-1:0]   bg_value;
	logic [KIND_W-1:0]  ul_kind;
	logic [RGB_W-1:0]   ul_value;
	logic [FLAGS_W-1:0] attr_flags;
	logic [SLOT_W-1:0]  palette_slot;
	logic [RGB_W-1:0]   palette_rgb;

	modport source (output valid, action, fg_kind, fg_value, bg_kind, bg_value, ul_kind,
		ul_value, attr_flags, palette_slot, palette_rgb, input ready);
	modport sink (input valid, action, fg_kind, fg_value, bg_kind, bg_value, ul_kind,
		ul_value, attr_flags, palette_slot, palette_rgb, output ready);
endinterface

interface tccr_result_if
	import tccr_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [RGB_W-1:0] fg_rgb;
	logic [RGB_W-1:0] bg_rgb;
	logic [RGB_W-1:0] line_rgb;
	logic             glyph_hidden;

	modport source (output valid, fg_rgb, bg_rgb, line_rgb, glyph_hidden, input ready);
	modport sink (input valid, fg_rgb, bg_rgb, line_rgb, glyph_hidden, output ready);
endinterface

FILE: rtl/tccr_regs.sv
// APB configuration registers holding the theme default colors.
module tccr_regs
	import tccr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [RGB_W-1:0]      default_fg,
	output logic [RGB_W-1:0]      default_bg
);

	localparam logic REG_DEFAULT_FG = 1'b0;
	localparam logic REG_DEFAULT_BG = 1'b1;

	logic [RGB_W-1:0] default_fg_q;
	logic [RGB_W-1:0] default_bg_q;
	logic             wr_en;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_fg_q <= DEFAULT_FG_RST;
			default_bg_q <= DEFAULT_BG_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_DEFAULT_FG: default_fg_q <= pwdata[RGB_W-1:0];
				REG_DEFAULT_BG: default_bg_q <= pwdata[RGB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_DEFAULT_FG: prdata = APB_DATA_W'(default_fg_q);
			REG_DEFAULT_BG: prdata = APB_DATA_W'(default_bg_q);
			default: prdata = '0;
		endcase
	end

	assign default_fg = default_fg_q;
	assign default_bg = default_bg_q;

endmodule

FILE: rtl/tccr_palette.sv
// ANSI palette storage: two mirrored synchronous memories giving three read ports.
module tccr_palette
	import tccr_pkg::*;
(
	input  logic             clk,
	input  pal_wr_t          wr,
	input  pal_rd_t          rd,
	output logic [RGB_W-1:0] fg_data,
	output logic [RGB_W-1:0] bg_data,
	output logic [RGB_W-1:0] ul_data
);

	localparam int DEPTH = 1 << SLOT_W;

	logic [RGB_W-1:0] color_mem [DEPTH];
	logic [RGB_W-1:0] line_mem  [DEPTH];
	logic [RGB_W-1:0] fg_data_q;
	logic [RGB_W-1:0] bg_data_q;
	logic [RGB_W-1:0] ul_data_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			color_mem[wr.addr] <= wr.data;
		if (rd.en) begin
			fg_data_q <= color_mem[rd.fg_addr];
			bg_data_q <= color_mem[rd.bg_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en)
			line_mem[wr.addr] <= wr.data;
		if (rd.en)
			ul_data_q <= line_mem[rd.ul_addr];
	end

	assign fg_data = fg_data_q;
	assign bg_data = bg_data_q;
	assign ul_data = ul_data_q;

endmodule

FILE: rtl/terminal_cell_color_resolver.sv
// Top level of the terminal cell color resolver.
// A resolve item passes the palette read and stage-1 registers, then the result registers.
// One item per cycle unless the result stalls; palette reads issue in the transfer cycle.
// Palette writes produce no result and take effect for the next item.
// Reset clears the pipeline valids and loads the default colors; the palette is not cleared.
module terminal_cell_color_resolver
	import tccr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	tccr_cell_if.sink             item,
	tccr_result_if.source         result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [RGB_W-1:0] default_fg;
	logic [RGB_W-1:0] default_bg;
	logic [RGB_W-1:0] pal_fg;
	logic [RGB_W-1:0] pal_bg;
	logic [RGB_W-1:0] pal_ul;
	pal_rd_t          pal_rd;
	pal_wr_t          pal_wr;

	logic               accept;
	logic               out_free;
	logic [INDEX_W-1:0] fg_idx;
	logic [INDEX_W-1:0] fg_idx_eff;
	logic [INDEX_W-1:0] bg_idx;
	logic [INDEX_W-1:0] ul_idx;
	logic               bold_hit;
	logic               fg_pal;
	logic               bg_pal;
	logic               ul_pal;
	logic               ul_set;
	logic [RGB_W-1:0]   fg_pre;
	logic [RGB_W-1:0]   bg_pre;
	logic [RGB_W-1:0]   ul_pre;

	logic               valid_s1;
	logic               fg_pal_s1;
	logic               bg_pal_s1;
	logic               ul_pal_s1;
	logic               ul_set_s1;
	logic [RGB_W-1:0]   fg_pre_s1;
	logic [RGB_W-1:0]   bg_pre_s1;
	logic [RGB_W-1:0]   ul_pre_s1;
	logic [FLAGS_W-1:0] flags_s1;

	logic [RGB_W-1:0] fg_look;
	logic [RGB_W-1:0] fg_dim;
	logic [RGB_W-1:0] fg_rev;
	logic [RGB_W-1:0] bg_rev;
	logic [RGB_W-1:0] fg_fin;
	logic [RGB_W-1:0] line_fin;

	logic             res_valid_q;
	logic [RGB_W-1:0] fg_rgb_q;
	logic [RGB_W-1:0] bg_rgb_q;
	logic [RGB_W-1:0] line_rgb_q;
	logic             hidden_q;

	tccr_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.default_fg (default_fg),
		.default_bg (default_bg)
	);

	tccr_palette u_palette (
		.clk     (clk),
		.wr      (pal_wr),
		.rd      (pal_rd),
		.fg_data (pal_fg),
		.bg_data (pal_bg),
		.ul_data (pal_ul)
	);

	assign out_free   = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || out_free;
	assign accept     = item.valid && item.ready;

	assign fg_idx     = item.fg_value[INDEX_W-1:0];
	assign bg_idx     = item.bg_value[INDEX_W-1:0];
	assign ul_idx     = item.ul_value[INDEX_W-1:0];
	assign bold_hit   = item.attr_flags[FLAG_BOLD] && (item.fg_kind == KIND_INDEX)
		&& (fg_idx < BRIGHT_BASE);
	assign fg_idx_eff = bold_hit ? fg_idx + BRIGHT_BASE : fg_idx;

	assign fg_pal = (item.fg_kind == KIND_INDEX) && (fg_idx_eff < ANSI_COUNT);
	assign bg_pal = (item.bg_kind == KIND_INDEX) && (bg_idx < ANSI_COUNT);
	assign ul_pal = (item.ul_kind == KIND_INDEX) && (ul_idx < ANSI_COUNT);
	assign ul_set = (item.ul_kind == KIND_INDEX) || (item.ul_kind == KIND_RGB);

	always_comb begin
		case (item.fg_kind)
			KIND_INDEX: fg_pre = index_rgb(fg_idx_eff);
			KIND_RGB: fg_pre = item.fg_value;
			default: fg_pre = default_fg;
		endcase
		case (item.bg_kind)
			KIND_INDEX: bg_pre = index_rgb(bg_idx);
			KIND_RGB: bg_pre = item.bg_value;
			default: bg_pre = default_bg;
		endcase
		case (item.ul_kind)
			KIND_INDEX: ul_pre = index_rgb(ul_idx);
			default: ul_pre = item.ul_value;
		endcase
	end

	assign pal_rd.en      = accept && (item.action == ACTION_RESOLVE);
	assign pal_rd.fg_addr = fg_idx_eff[SLOT_W-1:0];
	assign pal_rd.bg_addr = bg_idx[SLOT_W-1:0];
	assign pal_rd.ul_addr = ul_idx[SLOT_W-1:0];
	assign pal_wr.en      = accept && (item.action == ACTION_WRITE);
	assign pal_wr.addr    = item.palette_slot;
	assign pal_wr.data    = item.palette_rgb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= accept && (item.action == ACTION_RESOLVE);
		end
	end

	always_ff @(posedge clk) begin
		if (pal_rd.en) begin
			fg_pal_s1 <= fg_pal;
			bg_pal_s1 <= bg_pal;
			ul_pal_s1 <= ul_pal;
			ul_set_s1 <= ul_set;
			fg_pre_s1 <= fg_pre;
			bg_pre_s1 <= bg_pre;
			ul_pre_s1 <= ul_pre;
			flags_s1  <= item.attr_flags;
		end
	end

	assign fg_look  = fg_pal_s1 ? pal_fg : fg_pre_s1;
	assign fg_dim   = flags_s1[FLAG_DIM] ? ((fg_look >> 1) & HALF_MASK) : fg_look;
	assign bg_rev   = flags_s1[FLAG_REVERSE] ? fg_dim : (bg_pal_s1 ? pal_bg : bg_pre_s1);
	assign fg_rev   = flags_s1[FLAG_REVERSE] ? (bg_pal_s1 ? pal_bg : bg_pre_s1) : fg_dim;
	assign fg_fin   = flags_s1[FLAG_INVISIBLE] ? bg_rev : fg_rev;
	assign line_fin = ul_set_s1 ? (ul_pal_s1 ? pal_ul : ul_pre_s1) : fg_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			fg_rgb_q   <= fg_fin;
			bg_rgb_q   <= bg_rev;
			line_rgb_q <= line_fin;
			hidden_q   <= (fg_fin == bg_rev);
		end
	end

	assign result.valid        = res_valid_q;
	assign result.fg_rgb       = fg_rgb_q;
	assign result.bg_rgb       = bg_rgb_q;
	assign result.line_rgb     = line_rgb_q;
	assign result.glyph_hidden = hidden_q;

endmodule
